### hw/rtl/fbbc_pkg.sv
package fbbc_pkg;

  localparam int DIM_MAX   = 1024;
  localparam int VOXEL_W   = 16;
  localparam int POS_W     = $clog2(DIM_MAX);
  localparam int DIM_W     = POS_W + 1;
  localparam int MARGIN_W  = 12;
  localparam int FRAC_W    = 8;
  localparam int PROD_W    = DIM_W + MARGIN_W;
  localparam int SCALED_W  = POS_W + 4;
  localparam int HALF_W    = SCALED_W - 1;
  localparam int WIN_W     = SCALED_W + 2;
  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [DIM_W-1:0]    DIM_LIMIT  = DIM_W'(DIM_MAX);
  localparam logic [MARGIN_W-1:0] MARGIN_ONE = MARGIN_W'(1 << FRAC_W);

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 3'd4;

  typedef struct packed {
    logic [NUM_AXES-1:0][DIM_W-1:0] dim;
    logic [VOXEL_W-1:0]             background;
    logic [MARGIN_W-1:0]            margin;
  } cfg_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][POS_W-1:0] lo;
    logic [NUM_AXES-1:0][POS_W-1:0] hi;
    logic                           seen;
  } box_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][POS_W-1:0]    lo;
    logic [NUM_AXES-1:0][DIM_W-1:0]    ext;
    logic [NUM_AXES-1:0][SCALED_W-1:0] scaled;
    logic                              seen;
  } prod_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][WIN_W-1:0] first;
    logic [NUM_AXES-1:0][WIN_W-1:0] stop;
    logic                           seen;
  } win_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_LIMIT) begin
      r = DIM_LIMIT;
    end
    return r;
  endfunction

endpackage

### hw/rtl/fbbc_if.sv
interface fbbc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [fbbc_pkg::VOXEL_W-1:0] voxel_value;
  logic                               last_voxel;

  modport source(output valid, voxel_value, last_voxel, input ready);
  modport sink(input valid, voxel_value, last_voxel, output ready);
endinterface

interface fbbc_out_if;
  logic                           valid;
  logic                           ready;
  logic [fbbc_pkg::POS_W-1:0]     start_x;
  logic [fbbc_pkg::POS_W-1:0]     start_y;
  logic [fbbc_pkg::POS_W-1:0]     start_z;
  logic [fbbc_pkg::DIM_W-1:0]     extent_x;
  logic [fbbc_pkg::DIM_W-1:0]     extent_y;
  logic [fbbc_pkg::DIM_W-1:0]     extent_z;
  logic                           empty_volume;

  modport source(output valid, start_x, start_y, start_z, extent_x, extent_y, extent_z,
                 empty_volume, input ready);
  modport sink(input valid, start_x, start_y, start_z, extent_x, extent_y, extent_z,
               empty_volume, output ready);
endinterface

### hw/rtl/fbbc_scan.sv
module fbbc_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  fbbc_pkg::cfg_t      cfg,
  fbbc_in_if.sink             in_ch,
  output logic                box_valid,
  input  logic                box_ready,
  output fbbc_pkg::box_t      box
);

  logic [fbbc_pkg::NUM_AXES-1:0][fbbc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [fbbc_pkg::NUM_AXES-1:0][fbbc_pkg::POS_W-1:0] lo_r, hi_r;
  logic                                               seen_r;
  fbbc_pkg::box_t                                     upd;
  fbbc_pkg::box_t                                     box_r;
  logic                                               box_v_r;
  logic                                               fg;
  logic                                               accept;
  logic [fbbc_pkg::NUM_AXES-1:0]                      wrap;

  assign in_ch.ready = !box_v_r || box_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign fg          = in_ch.voxel_value != cfg.background;

  always_comb begin
    upd.seen = seen_r || fg;
    for (int i = 0; i < fbbc_pkg::NUM_AXES; i++) begin
      upd.lo[i] = (fg && pos_r[i] < lo_r[i]) ? pos_r[i] : lo_r[i];
      upd.hi[i] = (fg && pos_r[i] > hi_r[i]) ? pos_r[i] : hi_r[i];
    end
  end

  always_comb begin
    for (int i = 0; i < fbbc_pkg::NUM_AXES; i++) begin
      wrap[i] = ({1'b0, pos_r[i]} + fbbc_pkg::DIM_W'(1)) >= fbbc_pkg::eff_dim(cfg.dim[i]);
    end
    pos_nxt[0] = wrap[0] ? '0 : pos_r[0] + fbbc_pkg::POS_W'(1);
    pos_nxt[1] = pos_r[1];
    pos_nxt[2] = pos_r[2];
    if (wrap[0]) begin
      pos_nxt[1] = wrap[1] ? '0 : pos_r[1] + fbbc_pkg::POS_W'(1);
      if (wrap[1]) begin
        pos_nxt[2] = wrap[2] ? '0 : pos_r[2] + fbbc_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      lo_r    <= '1;
      hi_r    <= '0;
      seen_r  <= 1'b0;
      box_v_r <= 1'b0;
    end else begin
      if (accept) begin
        if (in_ch.last_voxel) begin
          pos_r  <= '0;
          lo_r   <= '1;
          hi_r   <= '0;
          seen_r <= 1'b0;
        end else begin
          pos_r  <= pos_nxt;
          lo_r   <= upd.lo;
          hi_r   <= upd.hi;
          seen_r <= upd.seen;
        end
      end
      if (accept && in_ch.last_voxel) begin
        box_v_r <= 1'b1;
      end else if (box_ready) begin
        box_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.last_voxel) begin
      box_r <= upd;
    end
  end

  assign box_valid = box_v_r;
  assign box       = box_r;

endmodule

### hw/rtl/fbbc_grow.sv
module fbbc_grow (
  input  logic           clk,
  input  logic           rst_n,
  input  fbbc_pkg::cfg_t cfg,
  input  logic           box_valid,
  output logic           box_ready,
  input  fbbc_pkg::box_t box,
  output logic           win_valid,
  input  logic           win_ready,
  output fbbc_pkg::win_t win
);

  fbbc_pkg::prod_t                                        prod_r, prod_nxt;
  fbbc_pkg::win_t                                         win_r, win_nxt;
  logic                                                   prod_v_r, win_v_r;
  logic                                                   prod_ready;
  logic [fbbc_pkg::NUM_AXES-1:0][fbbc_pkg::PROD_W-1:0]    full;
  logic [fbbc_pkg::MARGIN_W-1:0]                          scale;
  logic [fbbc_pkg::NUM_AXES-1:0][fbbc_pkg::SCALED_W-1:0]  growth;
  logic [fbbc_pkg::NUM_AXES-1:0][fbbc_pkg::HALF_W-1:0]    half;

  assign scale      = (cfg.margin < fbbc_pkg::MARGIN_ONE) ? fbbc_pkg::MARGIN_ONE : cfg.margin;
  assign prod_ready = !win_v_r || win_ready;
  assign box_ready  = !prod_v_r || prod_ready;

  always_comb begin
    prod_nxt.lo   = box.lo;
    prod_nxt.seen = box.seen;
    for (int i = 0; i < fbbc_pkg::NUM_AXES; i++) begin
      prod_nxt.ext[i]    = {1'b0, box.hi[i]} - {1'b0, box.lo[i]} + fbbc_pkg::DIM_W'(1);
      full[i]            = fbbc_pkg::PROD_W'(prod_nxt.ext[i]) * fbbc_pkg::PROD_W'(scale);
      prod_nxt.scaled[i] = full[i][fbbc_pkg::FRAC_W +: fbbc_pkg::SCALED_W];
    end
  end

  always_comb begin
    win_nxt.seen = prod_r.seen;
    for (int i = 0; i < fbbc_pkg::NUM_AXES; i++) begin
      growth[i]       = prod_r.scaled[i] - fbbc_pkg::SCALED_W'(prod_r.ext[i]);
      half[i]         = growth[i][fbbc_pkg::SCALED_W-1:1];
      win_nxt.first[i] = fbbc_pkg::WIN_W'(prod_r.lo[i]) - fbbc_pkg::WIN_W'(half[i]);
      win_nxt.stop[i]  = win_nxt.first[i] + fbbc_pkg::WIN_W'(prod_r.scaled[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      win_v_r  <= 1'b0;
    end else begin
      if (box_ready) begin
        prod_v_r <= box_valid;
      end
      if (prod_ready) begin
        win_v_r <= prod_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (box_ready && box_valid) begin
      prod_r <= prod_nxt;
    end
    if (prod_ready && prod_v_r) begin
      win_r <= win_nxt;
    end
  end

  assign win_valid = win_v_r;
  assign win       = win_r;

endmodule

### hw/rtl/fbbc_clip.sv
module fbbc_clip (
  input  logic           clk,
  input  logic           rst_n,
  input  fbbc_pkg::cfg_t cfg,
  input  logic           win_valid,
  output logic           win_ready,
  input  fbbc_pkg::win_t win,
  fbbc_out_if.source     out_ch
);

  logic [fbbc_pkg::NUM_AXES-1:0][fbbc_pkg::WIN_W-1:0] a, b;
  logic [fbbc_pkg::NUM_AXES-1:0][fbbc_pkg::WIN_W-1:0] size;
  logic [fbbc_pkg::NUM_AXES-1:0][fbbc_pkg::DIM_W-1:0] d;
  logic [fbbc_pkg::NUM_AXES-1:0][fbbc_pkg::POS_W-1:0] start_nxt, start_r;
  logic [fbbc_pkg::NUM_AXES-1:0][fbbc_pkg::DIM_W-1:0] extent_nxt, extent_r;
  logic                                               empty_r;
  logic                                               hit;
  logic                                               out_v_r;

  assign win_ready = !out_v_r || out_ch.ready;

  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < fbbc_pkg::NUM_AXES; i++) begin
      d[i] = fbbc_pkg::eff_dim(cfg.dim[i]);
      a[i] = $signed(win.first[i]) < 0 ? '0 : win.first[i];
      b[i] = ($signed(win.stop[i]) > $signed(fbbc_pkg::WIN_W'(d[i])))
             ? fbbc_pkg::WIN_W'(d[i]) : win.stop[i];
      size[i] = b[i] - a[i];
      if ($signed(b[i]) <= $signed(a[i])) begin
        hit = 1'b0;
      end
    end
    for (int i = 0; i < fbbc_pkg::NUM_AXES; i++) begin
      if (!win.seen) begin
        start_nxt[i]  = '0;
        extent_nxt[i] = d[i];
      end else if (!hit) begin
        start_nxt[i]  = '0;
        extent_nxt[i] = '0;
      end else begin
        start_nxt[i]  = a[i][fbbc_pkg::POS_W-1:0];
        extent_nxt[i] = size[i][fbbc_pkg::DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (win_ready) begin
      out_v_r <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (win_ready && win_valid) begin
      start_r  <= start_nxt;
      extent_r <= extent_nxt;
      empty_r  <= !win.seen;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.start_x      = start_r[0];
  assign out_ch.start_y      = start_r[1];
  assign out_ch.start_z      = start_r[2];
  assign out_ch.extent_x     = extent_r[0];
  assign out_ch.extent_y     = extent_r[1];
  assign out_ch.extent_z     = extent_r[2];
  assign out_ch.empty_volume = empty_r;

endmodule

### hw/rtl/foreground_bounding_box_crop_unit.sv
// Streams voxels of one or more 3D volumes in raster order (x fastest) and
// tracks the bounding box of every voxel that differs from the background
// level, counting positions internally against the configured dimensions. The
// beat marked last_voxel is counted and then yields one crop region: the box
// grown by the Q4.8 margin factor, centered, and clipped to the volume, or the
// whole volume with empty_volume set when no foreground was seen. One voxel is
// taken per clock while the output path is not stalled; the result of the last
// voxel passes the scan register, the margin multiply, the centering adders and
// the output register in turn. Configure only while no result is pending.
module foreground_bounding_box_crop_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  fbbc_in_if.sink                          in_ch,
  fbbc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [fbbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbbc_pkg::CFG_W-1:0]       cfg_wdata
);

  fbbc_pkg::cfg_t cfg_r, cfg_nxt;
  fbbc_pkg::box_t box;
  fbbc_pkg::win_t win;
  logic           box_valid, box_ready;
  logic           win_valid, win_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    case (cfg_index)
      fbbc_pkg::CFG_DIM_X:      cfg_nxt.dim[0]     = cfg_wdata[fbbc_pkg::DIM_W-1:0];
      fbbc_pkg::CFG_DIM_Y:      cfg_nxt.dim[1]     = cfg_wdata[fbbc_pkg::DIM_W-1:0];
      fbbc_pkg::CFG_DIM_Z:      cfg_nxt.dim[2]     = cfg_wdata[fbbc_pkg::DIM_W-1:0];
      fbbc_pkg::CFG_BACKGROUND: cfg_nxt.background = cfg_wdata[fbbc_pkg::VOXEL_W-1:0];
      fbbc_pkg::CFG_MARGIN:     cfg_nxt.margin     = cfg_wdata[fbbc_pkg::MARGIN_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim        <= {fbbc_pkg::NUM_AXES{fbbc_pkg::DIM_LIMIT}};
      cfg_r.background <= '0;
      cfg_r.margin     <= fbbc_pkg::MARGIN_ONE;
    end else if (cfg_we) begin
      cfg_r <= cfg_nxt;
    end
  end

  fbbc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box)
  );

  fbbc_grow u_grow (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win)
  );

  fbbc_clip u_clip (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .out_ch    (out_ch)
  );

endmodule

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fbbc_pkg::*;

  localparam int LATENCY_SLACK = 8;
  localparam int LONG_HOLD     = 80;
  localparam int RANDOM_VOXELS = 1030;
  localparam int CALM_FROM     = 920;

  typedef struct packed {
    logic [NUM_AXES-1:0][POS_W-1:0] start;
    logic [NUM_AXES-1:0][DIM_W-1:0] extent;
    logic                           empty_volume;
  } region_t;

  class crop_region_tracker;
    logic [DIM_W-1:0]    dims [NUM_AXES];
    logic [VOXEL_W-1:0]  background;
    logic [MARGIN_W-1:0] margin;
    logic [POS_W-1:0]    pos [NUM_AXES];
    logic [POS_W-1:0]    lo_c [NUM_AXES];
    logic [POS_W-1:0]    hi_c [NUM_AXES];
    bit                  seen;
    region_t             pending_regions[$];
    int                  failures;
    int                  checked;
    int                  empties;
    int                  voxels_taken;

    function new();
      for (int i = 0; i < NUM_AXES; i++) begin
        dims[i] = DIM_W'(DIM_MAX);
      end
      background = '0;
      margin = MARGIN_ONE;
      clear_scan();
    endfunction

    function void clear_scan();
      for (int i = 0; i < NUM_AXES; i++) begin
        pos[i] = '0;
        lo_c[i] = '1;
        hi_c[i] = '0;
      end
      seen = 1'b0;
    endfunction

    function int usable_dim(logic [DIM_W-1:0] d);
      if (d == '0) begin
        return 1;
      end
      if (d > DIM_W'(DIM_MAX)) begin
        return DIM_MAX;
      end
      return int'(d);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_DIM_X: dims[0] = data[DIM_W-1:0];
        CFG_DIM_Y: dims[1] = data[DIM_W-1:0];
        CFG_DIM_Z: dims[2] = data[DIM_W-1:0];
        CFG_BACKGROUND: background = data[VOXEL_W-1:0];
        CFG_MARGIN: margin = data[MARGIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_voxel(logic [VOXEL_W-1:0] v, bit last);
      longint  ext;
      longint  grown;
      longint  first;
      longint  stop;
      longint  lim;
      longint  scale;
      bit      hit;
      bit      carry;
      region_t r;
      voxels_taken++;
      if (v != background) begin
        seen = 1'b1;
        for (int i = 0; i < NUM_AXES; i++) begin
          if (pos[i] < lo_c[i]) lo_c[i] = pos[i];
          if (pos[i] > hi_c[i]) hi_c[i] = pos[i];
        end
      end
      carry = 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
        if (carry) begin
          if (int'(pos[i]) + 1 >= usable_dim(dims[i])) begin
            pos[i] = '0;
          end else begin
            pos[i] = pos[i] + 1'b1;
            carry = 1'b0;
          end
        end
      end
      if (!last) return;
      r = '0;
      hit = 1'b1;
      scale = (margin < MARGIN_ONE) ? longint'(MARGIN_ONE) : longint'(margin);
      if (!seen) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          r.extent[i] = DIM_W'(usable_dim(dims[i]));
        end
        r.empty_volume = 1'b1;
      end else begin
        for (int i = 0; i < NUM_AXES; i++) begin
          ext = longint'(hi_c[i]) - longint'(lo_c[i]) + 1;
          grown = (ext * scale) / 256;
          first = longint'(lo_c[i]) - (grown - ext) / 2;
          stop = first + grown;
          lim = usable_dim(dims[i]);
          if (first < 0) first = 0;
          if (stop > lim) stop = lim;
          if (stop <= first) hit = 1'b0;
          r.start[i] = POS_W'(first);
          r.extent[i] = DIM_W'(stop - first);
        end
        if (!hit) r = '0;
      end
      pending_regions.push_back(r);
      clear_scan();
    endfunction

    function void complain(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_region(region_t got);
      region_t want;
      string   axis;
      axis = "xyz";
      checked++;
      if (pending_regions.size() == 0) begin
        complain($sformatf("region %0d arrived with no voxel series pending", checked));
        return;
      end
      want = pending_regions.pop_front();
      if (want.empty_volume) empties++;
      for (int i = 0; i < NUM_AXES; i++) begin
        if (got.start[i] !== want.start[i])
          complain($sformatf("region %0d start_%c: expected %0d, got %0d", checked,
                             axis[i], want.start[i], got.start[i]));
        if (got.extent[i] !== want.extent[i])
          complain($sformatf("region %0d extent_%c: expected %0d, got %0d", checked,
                             axis[i], want.extent[i], got.extent[i]));
      end
      if (got.empty_volume !== want.empty_volume)
        complain($sformatf("region %0d empty_volume: expected %0d, got %0d", checked,
                           want.empty_volume, got.empty_volume));
    endfunction

    function void close_out();
      if (pending_regions.size() != 0)
        complain($sformatf("%0d expected regions never arrived", pending_regions.size()));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  fbbc_in_if  in_ch ();
  fbbc_out_if out_ch ();

  crop_region_tracker regions = new();

  bit long_hold_req;
  bit calm_tail;
  int idle_pct;
  int stall_pct;
  int random_items;
  int settings;

  foreground_bounding_box_crop_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin : result_monitor
    region_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.start[0] = out_ch.start_x;
      got.start[1] = out_ch.start_y;
      got.start[2] = out_ch.start_z;
      got.extent[0] = out_ch.extent_x;
      got.extent[1] = out_ch.extent_y;
      got.extent[2] = out_ch.extent_z;
      got.empty_volume = out_ch.empty_volume;
      regions.check_region(got);
    end
  end

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (calm_tail || $urandom_range(99) >= stall_pct) begin
        out_ch.ready <= 1'b1;
        repeat (calm_tail ? 1 : $urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  task automatic send_voxel(logic [VOXEL_W-1:0] v, bit last);
    in_ch.valid <= 1'b1;
    in_ch.voxel_value <= v;
    in_ch.last_voxel <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    regions.take_voxel(v, last);
  endtask

  task automatic send_random_voxel(int fg_pct, bit last);
    logic [VOXEL_W-1:0] v;
    if (!calm_tail && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    v = regions.background;
    if ($urandom_range(99) < fg_pct) begin
      case ($urandom_range(7))
        0: v = 16'h8000;
        1: v = 16'h7FFF;
        2: v = ~regions.background;
        default: v = VOXEL_W'($urandom);
      endcase
    end
    send_voxel(v, last);
    random_items++;
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    regions.write_register(idx, data);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (regions.pending_regions.size() != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
    settings++;
  endtask

  function automatic int pick_dim();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(DIM_MAX + 1, 2047);
      2: return 1;
      3: return DIM_MAX;
      4: return $urandom_range(7, DIM_MAX - 1);
      default: return $urandom_range(2, 6);
    endcase
  endfunction

  task automatic random_phase();
    int vol;
    int n;
    int fg_pct;
    int choice;
    int pcts[3];
    int fgs[5];
    logic [CFG_W-1:0] bg;
    logic [CFG_W-1:0] scale;
    pcts = '{0, 15, 40};
    fgs = '{0, 3, 20, 60, 100};
    wait_idle();
    set_register(CFG_DIM_X, CFG_W'(pick_dim()));
    set_register(CFG_DIM_Y, CFG_W'(pick_dim()));
    set_register(CFG_DIM_Z, CFG_W'(pick_dim()));
    case ($urandom_range(5))
      0: bg = 16'h8000;
      1: bg = 16'h7FFF;
      2: bg = '0;
      default: bg = CFG_W'($urandom);
    endcase
    set_register(CFG_BACKGROUND, bg);
    case ($urandom_range(5))
      0: scale = CFG_W'($urandom_range(0, 255));
      1: scale = CFG_W'(MARGIN_ONE);
      2: scale = 16'd4095;
      default: scale = CFG_W'($urandom_range(256, 4095));
    endcase
    set_register(CFG_MARGIN, scale);
    cfg_we <= 1'b0;
    idle_pct = pcts[$urandom_range(2)];
    stall_pct = pcts[$urandom_range(2)];
    fg_pct = fgs[$urandom_range(4)];
    vol = 1;
    for (int i = 0; i < NUM_AXES; i++) begin
      vol = vol * regions.usable_dim(regions.dims[i]);
    end
    choice = $urandom_range(99);
    if (vol <= 120 && choice < 75) begin
      n = vol * $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        send_random_voxel(fg_pct, k == n - 1);
      end
    end else begin
      n = $urandom_range(1, 60);
      for (int k = 0; k < n; k++) begin
        send_random_voxel(fg_pct, k == n - 1 && choice < 88);
      end
    end
  endtask

  task automatic pressure_phase();
    wait_idle();
    set_register(CFG_DIM_X, CFG_W'(1));
    set_register(CFG_DIM_Y, CFG_W'(1));
    set_register(CFG_DIM_Z, CFG_W'(1));
    set_register(CFG_MARGIN, CFG_W'($urandom_range(0, 4095)));
    cfg_we <= 1'b0;
    idle_pct = 0;
    long_hold_req = 1'b1;
    for (int k = 0; k < 30; k++) begin
      send_random_voxel(50, 1'b1);
    end
  endtask

  initial begin : stimulus
    in_ch.valid <= 1'b0;
    in_ch.voxel_value <= '0;
    in_ch.last_voxel <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: full-size volume, background 0, unit margin.
    send_voxel(16'h0000, 1'b0);
    send_voxel(16'h7FFF, 1'b0);
    send_voxel(16'h8000, 1'b0);
    send_voxel(16'h0000, 1'b0);
    send_voxel(16'hFFFF, 1'b1);
    send_voxel(16'h0000, 1'b1);
    send_voxel(16'h0001, 1'b1);

    // A zero dim acts as one, an oversized dim as the maximum, a small margin as one.
    wait_idle();
    set_register(CFG_DIM_X, 16'd0);
    set_register(CFG_DIM_Y, 16'd2047);
    set_register(CFG_DIM_Z, 16'd3);
    set_register(CFG_BACKGROUND, 16'h8000);
    set_register(CFG_MARGIN, 16'd0);
    cfg_we <= 1'b0;
    send_voxel(16'h8000, 1'b0);
    send_voxel(16'h0000, 1'b0);
    send_voxel(16'h8000, 1'b0);
    send_voxel(16'h8001, 1'b1);

    // Shrink x while the scan sits past the new width, so the grown box misses.
    wait_idle();
    set_register(CFG_DIM_X, 16'd8);
    set_register(CFG_DIM_Y, 16'd1);
    set_register(CFG_DIM_Z, 16'd1);
    set_register(CFG_BACKGROUND, 16'h0000);
    cfg_we <= 1'b0;
    for (int k = 0; k < 6; k++) begin
      send_voxel(16'h0000, 1'b0);
    end
    send_voxel(16'hA5A5, 1'b0);
    wait_idle();
    set_register(CFG_DIM_X, 16'd2);
    set_register(CFG_MARGIN, 16'd256);
    cfg_we <= 1'b0;
    send_voxel(16'h0000, 1'b1);

    // Largest margin, clipped at both ends of the row.
    wait_idle();
    set_register(CFG_DIM_X, 16'd5);
    set_register(CFG_BACKGROUND, 16'h7FFF);
    set_register(CFG_MARGIN, 16'd4095);
    cfg_we <= 1'b0;
    send_voxel(16'h7FFF, 1'b0);
    send_voxel(16'h0000, 1'b0);
    send_voxel(16'h7FFF, 1'b1);

    while (random_items < RANDOM_VOXELS) begin
      if (random_items >= CALM_FROM) calm_tail = 1'b1;
      if (settings == 5) pressure_phase();
      else random_phase();
    end

    in_ch.valid <= 1'b0;
    while (regions.pending_regions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    regions.close_out();
    $display("Streamed %0d voxels over %0d register settings, including a long output stall.",
             regions.voxels_taken, settings);
    $display("Checked %0d crop regions, %0d of them for volumes without foreground.",
             regions.checked, regions.empties);
    if (regions.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
